// File: rtl/scvr_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants of the supply current/voltage regulator.
// No dependencies; used by every other file of the block.
package scvr_pkg;

    // Payload widths
    localparam int SAMPLE_W = 10;
    localparam int WSUM_W   = 16;
    localparam int CFG_W    = 10;
    localparam int CNT_W    = 4;
    localparam int VOLT_W   = 8;
    localparam int AMP_W    = 9;
    localparam int PHASE_W  = 10;
    localparam int LEVEL_W  = 13;
    localparam int CACC_W   = 14;

    // Bus widths
    localparam int AXIS_W = 32;
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    // Default build values
    localparam int VOLT_SAMPLES_DEF = 8;
    localparam int WINDOW_LEN_DEF   = 50;

    // Converter full scale and derived limits
    localparam int ADC_MAX    = 1023;
    localparam int LEVEL_MAX  = 4960;
    localparam int CUR_LEVELS = 2;
    localparam int CACC_CAP   = CUR_LEVELS * LEVEL_MAX;
    localparam int PHASE_LOW  = 10;
    localparam int PHASE_HIGH = 1000;
    localparam int PHASE_RST  = PHASE_HIGH;

    // floor(avg * 157 / 1023) as a multiply by a rounded-up reciprocal
    localparam int VOLT_SCALE = 157;
    localparam int VOLT_SH    = 21;
    localparam int VOLT_MUL   = (VOLT_SCALE * (1 << VOLT_SH) + ADC_MAX - 1) / ADC_MAX;
    localparam int VOLT_MUL_W = 19;

    // floor(floor(sum / 2) / 17) == floor(sum / 34)
    localparam int AMP_DIV   = CUR_LEVELS * 17;
    localparam int AMP_SH    = 20;
    localparam int AMP_MUL   = ((1 << AMP_SH) + AMP_DIV - 1) / AMP_DIV;
    localparam int AMP_MUL_W = 15;
    localparam int AMP_MAX   = CACC_CAP / AMP_DIV;

    // Register reset values
    localparam int CUR_SP_RST  = 15;
    localparam int VOLT_SP_RST = 138;

    typedef enum logic [1:0] {
        REG_CUR_SP  = 2'd0,
        REG_VOLT_SP = 2'd1,
        REG_VMODE   = 2'd2,
        REG_OEN     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] current_setpoint;
        logic [CFG_W-1:0] voltage_setpoint;
        logic             voltage_mode;
        logic             output_enable;
    } cfg_t;

endpackage

// File: rtl/scvr_cfg.sv
`timescale 1ns / 1ps
// APB register bank of the regulator: setpoints, mode and output enable.
// Depends on scvr_pkg.
module scvr_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [scvr_pkg::APB_AW-1:0]  paddr,
    input  logic [scvr_pkg::APB_DW-1:0]  pwdata,
    output logic [scvr_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output scvr_pkg::cfg_t               cfg
);

    scvr_pkg::cfg_t     cfg_reg;
    scvr_pkg::cfg_t     cfg_next;
    scvr_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = scvr_pkg::reg_idx_t'(paddr[scvr_pkg::APB_AW-1:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                scvr_pkg::REG_CUR_SP:  cfg_next.current_setpoint = pwdata[scvr_pkg::CFG_W-1:0];
                scvr_pkg::REG_VOLT_SP: cfg_next.voltage_setpoint = pwdata[scvr_pkg::CFG_W-1:0];
                scvr_pkg::REG_VMODE:   cfg_next.voltage_mode     = pwdata[0];
                scvr_pkg::REG_OEN:     cfg_next.output_enable    = pwdata[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_setpoint <= scvr_pkg::CFG_W'(scvr_pkg::CUR_SP_RST);
            cfg_reg.voltage_setpoint <= scvr_pkg::CFG_W'(scvr_pkg::VOLT_SP_RST);
            cfg_reg.voltage_mode     <= 1'b0;
            cfg_reg.output_enable    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            scvr_pkg::REG_CUR_SP:  prdata = scvr_pkg::APB_DW'(cfg_reg.current_setpoint);
            scvr_pkg::REG_VOLT_SP: prdata = scvr_pkg::APB_DW'(cfg_reg.voltage_setpoint);
            scvr_pkg::REG_VMODE:   prdata = scvr_pkg::APB_DW'(cfg_reg.voltage_mode);
            scvr_pkg::REG_OEN:     prdata = scvr_pkg::APB_DW'(cfg_reg.output_enable);
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/supply_current_voltage_regulator.sv
`timescale 1ns / 1ps
// Regulator of a phase-controlled supply: sample averaging, current level,
// phase delay and gate control. Depends on scvr_pkg and scvr_cfg.
//
// Usage:
//   s_* carries one converter event per transaction: s_tuser says which
//   channel was converted, s_tdata holds the voltage sample and the current
//   window sum. m_* returns one result per event: both readings, the phase
//   delay, the limit flag, the gate level and the channel to convert next.
//   The APB port sets the setpoints, the mode and the output enable; write
//   it only while no event is in flight.
// Timing:
//   Accepted events pass stages 1 to 5 and the output stage to m_*, one per
//   cycle unless a stall backs them up. The counter and voltage accumulator
//   update at acceptance; the reciprocal multiplies take stages 2, 3 and 5,
//   the current accumulator stage 4 and the phase/gate update the output stage.
// Reset:
//   All stages empty, counters and accumulators zero, phase delay 1000,
//   registers back to their defaults.
// Stall:
//   While m_tready is low the result holds; the stages behind it keep
//   filling, and s_tready drops once all six stages hold an event.
module supply_current_voltage_regulator #(
    parameter int VOLT_SAMPLES = scvr_pkg::VOLT_SAMPLES_DEF,
    parameter int WINDOW_LEN   = scvr_pkg::WINDOW_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // s_tdata: voltage_sample[9:0], window_sum[25:10], zero[31:26]
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [scvr_pkg::AXIS_W-1:0]  s_tdata,
    // s_tuser: func[0]
    input  logic [0:0]                   s_tuser,
    // m_tdata: voltage_reading[7:0], current_reading[16:8], phase_delay[26:17],
    //          limit_flag[27], gate_on[28], next_channel[29], zero[31:30]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [scvr_pkg::AXIS_W-1:0]  m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [scvr_pkg::APB_AW-1:0]  paddr,
    input  logic [scvr_pkg::APB_DW-1:0]  pwdata,
    output logic [scvr_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    localparam int SW = scvr_pkg::SAMPLE_W;
    localparam int WW = scvr_pkg::WSUM_W;
    localparam int NW = scvr_pkg::CNT_W;
    localparam int CW = scvr_pkg::CFG_W;
    localparam int PW = scvr_pkg::PHASE_W;

    localparam int VACC_CAP = scvr_pkg::ADC_MAX * VOLT_SAMPLES;
    localparam int VACC_W   = $clog2(VACC_CAP + 1);
    localparam int AVG_SH   = VACC_W + $clog2(VOLT_SAMPLES);
    localparam longint unsigned AVG_MUL =
        ((64'd1 << AVG_SH) + 64'(VOLT_SAMPLES) - 64'd1) / 64'(VOLT_SAMPLES);
    localparam int AVG_MUL_W = $clog2(AVG_MUL + 64'd1);
    localparam int AVG_PW    = VACC_W + AVG_MUL_W;

    localparam int FULL   = scvr_pkg::ADC_MAX * WINDOW_LEN;
    localparam int FULL_W = $clog2(FULL + 1);
    localparam int CMP_W  = (FULL_W > WW) ? FULL_W : WW;
    localparam int LVL_SH = 2 * $clog2(FULL);
    localparam longint unsigned LVL_MUL =
        ((64'(scvr_pkg::LEVEL_MAX) << LVL_SH) + 64'(FULL) - 64'd1) / 64'(FULL);
    localparam int LVL_MUL_W = $clog2(LVL_MUL + 64'd1);
    localparam int LVL_PW    = WW + LVL_MUL_W;

    localparam int VPROD_W = SW + scvr_pkg::VOLT_MUL_W;
    localparam int APROD_W = scvr_pkg::CACC_W + scvr_pkg::AMP_MUL_W;
    localparam int STAGES  = 6;

    scvr_pkg::cfg_t cfg;

    scvr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------------------------------------------------------
    // Stage valids and flow control
    // ---------------------------------------------------------------
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] vin;
    logic [STAGES-1:0] load;
    logic [STAGES:0]   rdy;

    always_comb
    begin
        rdy[STAGES] = m_tready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vin      = {vld_reg[STAGES-2:0], s_tvalid};
    assign load     = rdy[STAGES-1:0] & vin;
    assign vld_next = (rdy[STAGES-1:0] & vin) | (~rdy[STAGES-1:0] & vld_reg);
    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // ---------------------------------------------------------------
    // Front: shared counter, channel and voltage accumulator
    // ---------------------------------------------------------------
    logic              in_func;
    logic [SW-1:0]     in_sample;
    logic [WW-1:0]     in_wsum;

    logic [NW-1:0]     cnt_reg, cnt_next;
    logic              chan_reg, chan_next;
    logic [VACC_W-1:0] vacc_reg, vacc_next;

    logic [VACC_W:0]   vsum;
    logic [VACC_W-1:0] vacc_sat;
    logic [NW:0]       vinc;
    logic [NW:0]       cinc;
    logic [NW-1:0]     cnt_mid;
    logic              chan_mid;
    logic              f_vhit;
    logic              f_docur;
    logic              f_chit;
    logic [WW-1:0]     s_clamp;

    assign in_func   = s_tuser[0];
    assign in_sample = s_tdata[SW-1:0];
    assign in_wsum   = s_tdata[SW+WW-1:SW];

    always_comb
    begin
        vsum     = (VACC_W+1)'(vacc_reg) + (VACC_W+1)'(in_sample);
        vacc_sat = (vsum > (VACC_W+1)'(VACC_CAP)) ? VACC_W'(VACC_CAP) : vsum[VACC_W-1:0];

        // voltage step
        vinc      = (NW+1)'(cnt_reg) + (NW+1)'(1);
        f_vhit    = !in_func && (vinc == (NW+1)'(VOLT_SAMPLES));
        cnt_mid   = cnt_reg;
        chan_mid  = chan_reg;
        vacc_next = vacc_reg;
        if (!in_func)
        begin
            cnt_mid   = f_vhit ? '0 : vinc[NW-1:0];
            chan_mid  = f_vhit ? 1'b1 : chan_reg;
            vacc_next = f_vhit ? '0 : vacc_sat;
        end

        // current step, on the same transaction once the channel is current
        f_docur   = in_func || chan_mid;
        cinc      = (NW+1)'(cnt_mid) + (NW+1)'(1);
        f_chit    = f_docur && (cinc == (NW+1)'(scvr_pkg::CUR_LEVELS));
        cnt_next  = cnt_mid;
        chan_next = chan_mid;
        if (f_docur)
        begin
            cnt_next  = f_chit ? '0 : cinc[NW-1:0];
            chan_next = f_chit ? 1'b0 : chan_mid;
        end

        s_clamp = (CMP_W'(in_wsum) > CMP_W'(FULL)) ? WW'(FULL) : in_wsum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            chan_reg <= 1'b0;
            vacc_reg <= '0;
        end
        else if (load[0])
        begin
            cnt_reg  <= cnt_next;
            chan_reg <= chan_next;
            vacc_reg <= vacc_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: event flags, accumulated voltage, clamped window sum
    // ---------------------------------------------------------------
    logic              p1_vhit_reg, p1_docur_reg, p1_chit_reg, p1_chan_reg;
    logic [VACC_W-1:0] p1_vacc_reg;
    logic [WW-1:0]     p1_s_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            p1_vhit_reg  <= f_vhit;
            p1_docur_reg <= f_docur;
            p1_chit_reg  <= f_chit;
            p1_chan_reg  <= chan_next;
            p1_vacc_reg  <= vacc_sat;
            p1_s_reg     <= s_clamp;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: reciprocal products for the average and the level
    // ---------------------------------------------------------------
    logic              p2_vhit_reg, p2_docur_reg, p2_chit_reg, p2_chan_reg;
    logic [AVG_PW-1:0] p2_avgprod_reg, p2_avgprod_next;
    logic [LVL_PW-1:0] p2_lvlprod_reg, p2_lvlprod_next;

    assign p2_avgprod_next = AVG_PW'(p1_vacc_reg) * AVG_PW'(AVG_MUL);
    assign p2_lvlprod_next = LVL_PW'(p1_s_reg) * LVL_PW'(LVL_MUL);

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            p2_vhit_reg    <= p1_vhit_reg;
            p2_docur_reg   <= p1_docur_reg;
            p2_chit_reg    <= p1_chit_reg;
            p2_chan_reg    <= p1_chan_reg;
            p2_avgprod_reg <= p2_avgprod_next;
            p2_lvlprod_reg <= p2_lvlprod_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: scale the average, take the integer level
    // ---------------------------------------------------------------
    logic                        p3_vhit_reg, p3_docur_reg, p3_chit_reg, p3_chan_reg;
    logic [VPROD_W-1:0]          p3_vprod_reg, p3_vprod_next;
    logic [scvr_pkg::LEVEL_W-1:0] p3_level_reg, p3_level_next;
    logic [SW-1:0]               avg;

    assign avg           = SW'(p2_avgprod_reg >> AVG_SH);
    assign p3_vprod_next = VPROD_W'(avg) * VPROD_W'(scvr_pkg::VOLT_MUL);
    assign p3_level_next = scvr_pkg::LEVEL_W'(p2_lvlprod_reg >> LVL_SH);

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            p3_vhit_reg  <= p2_vhit_reg;
            p3_docur_reg <= p2_docur_reg;
            p3_chit_reg  <= p2_chit_reg;
            p3_chan_reg  <= p2_chan_reg;
            p3_vprod_reg <= p3_vprod_next;
            p3_level_reg <= p3_level_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: current accumulator and previous level
    // ---------------------------------------------------------------
    logic [scvr_pkg::CACC_W-1:0]  cacc_reg, cacc_next;
    logic [scvr_pkg::LEVEL_W-1:0] lvl_reg, lvl_next;
    logic [scvr_pkg::CACC_W-1:0]  csum_raw;
    logic [scvr_pkg::CACC_W-1:0]  csum;

    logic                          p4_vhit_reg, p4_chit_reg, p4_chan_reg;
    logic [scvr_pkg::VOLT_W-1:0]   p4_volt_reg, p4_volt_next;
    logic [scvr_pkg::CACC_W-1:0]   p4_csum_reg;

    always_comb
    begin
        csum_raw = cacc_reg + scvr_pkg::CACC_W'(lvl_reg);
        csum     = (csum_raw > scvr_pkg::CACC_W'(scvr_pkg::CACC_CAP))
                   ? scvr_pkg::CACC_W'(scvr_pkg::CACC_CAP) : csum_raw;
        cacc_next = cacc_reg;
        lvl_next  = lvl_reg;
        if (p3_docur_reg)
        begin
            cacc_next = p3_chit_reg ? '0 : csum;
            lvl_next  = p3_level_reg;
        end
        p4_volt_next = scvr_pkg::VOLT_W'(p3_vprod_reg >> scvr_pkg::VOLT_SH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cacc_reg <= '0;
            lvl_reg  <= '0;
        end
        else if (load[3])
        begin
            cacc_reg <= cacc_next;
            lvl_reg  <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            p4_vhit_reg <= p3_vhit_reg;
            p4_chit_reg <= p3_chit_reg;
            p4_chan_reg <= p3_chan_reg;
            p4_volt_reg <= p4_volt_next;
            p4_csum_reg <= csum;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: divide the level sum by 34
    // ---------------------------------------------------------------
    logic                        p5_vhit_reg, p5_chit_reg, p5_chan_reg;
    logic [scvr_pkg::VOLT_W-1:0] p5_volt_reg;
    logic [APROD_W-1:0]          p5_aprod_reg, p5_aprod_next;

    assign p5_aprod_next = APROD_W'(p4_csum_reg) * APROD_W'(scvr_pkg::AMP_MUL);

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            p5_vhit_reg  <= p4_vhit_reg;
            p5_chit_reg  <= p4_chit_reg;
            p5_chan_reg  <= p4_chan_reg;
            p5_volt_reg  <= p4_volt_reg;
            p5_aprod_reg <= p5_aprod_next;
        end
    end

    // ---------------------------------------------------------------
    // Output stage: readings, limit, phase and gate
    // ---------------------------------------------------------------
    logic [scvr_pkg::VOLT_W-1:0] volt_reg, volt_next;
    logic [scvr_pkg::AMP_W-1:0]  amp_reg, amp_next;
    logic [PW-1:0]               phase_reg, phase_next;
    logic                        limit_reg, limit_next;
    logic                        gate_reg, gate_next;
    logic                        ochan_reg;
    logic [scvr_pkg::AMP_W-1:0]  amp_new;

    always_comb
    begin
        amp_new    = scvr_pkg::AMP_W'(p5_aprod_reg >> scvr_pkg::AMP_SH);
        volt_next  = volt_reg;
        limit_next = limit_reg;
        amp_next   = amp_reg;
        phase_next = phase_reg;
        gate_next  = gate_reg;

        if (p5_vhit_reg)
        begin
            volt_next  = p5_volt_reg;
            limit_next = (CW'(p5_volt_reg) >= cfg.voltage_setpoint) && cfg.voltage_mode;
        end

        if (p5_chit_reg)
        begin
            amp_next = amp_new;
            // nudge the firing delay toward the current setpoint
            if (!limit_next || !cfg.voltage_mode)
            begin
                priority if (cfg.current_setpoint > CW'(amp_new)
                             && phase_reg > PW'(scvr_pkg::PHASE_LOW))
                    phase_next = phase_reg - PW'(1);
                else if (cfg.current_setpoint < CW'(amp_new)
                         && phase_reg < PW'(scvr_pkg::PHASE_HIGH))
                    phase_next = phase_reg + PW'(1);
            end
            if ((cfg.voltage_mode || limit_next) && cfg.output_enable)
                gate_next = cfg.voltage_setpoint >= CW'(volt_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_reg  <= '0;
            amp_reg   <= '0;
            phase_reg <= PW'(scvr_pkg::PHASE_RST);
            limit_reg <= 1'b0;
            gate_reg  <= 1'b0;
            ochan_reg <= 1'b0;
        end
        else if (load[STAGES-1])
        begin
            volt_reg  <= volt_next;
            amp_reg   <= amp_next;
            phase_reg <= phase_next;
            limit_reg <= limit_next;
            gate_reg  <= gate_next;
            ochan_reg <= p5_chan_reg;
        end
    end

    assign m_tdata = {2'b00, ochan_reg, gate_reg, limit_reg, phase_reg, amp_reg, volt_reg};

endmodule

// File: rtl/scvr_check.sv
`timescale 1ns / 1ps
// Port-level checks of the regulator's result channel, bound to the top level.
// Depends on scvr_pkg and supply_current_voltage_regulator.
module scvr_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [scvr_pkg::AXIS_W-1:0] m_tdata
);

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Phase delay never leaves its window
    a_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[26:17] >= scvr_pkg::PHASE_W'(scvr_pkg::PHASE_LOW))
                  && (m_tdata[26:17] <= scvr_pkg::PHASE_W'(scvr_pkg::PHASE_HIGH)))
        else $error("phase delay out of range");

    // Scaled readings stay within their full scale
    a_readings: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] <= scvr_pkg::VOLT_W'(scvr_pkg::VOLT_SCALE))
                  && (m_tdata[16:8] <= scvr_pkg::AMP_W'(scvr_pkg::AMP_MAX)))
        else $error("reading above full scale");

endmodule

bind supply_current_voltage_regulator scvr_check u_scvr_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/supply_current_voltage_regulator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the supply current/voltage regulator: stream and
// APB stimulus, a cycle-free predictor of the readings and an in-order check.
// Depends on scvr_pkg and supply_current_voltage_regulator.
module supply_current_voltage_regulator_tb;

    localparam int N_VOLT       = scvr_pkg::VOLT_SAMPLES_DEF;
    localparam int WIN_FULL     = scvr_pkg::WINDOW_LEN_DEF * scvr_pkg::ADC_MAX;
    localparam int STALL_PCT    = 18;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 40;

    localparam logic CH_VOLT = 1'b0;
    localparam logic CH_CUR  = 1'b1;

    // Same bit order as m_tdata[29:0]: first member is the MSB.
    typedef struct packed {
        logic                         chan;
        logic                         gate;
        logic                         limit;
        logic [scvr_pkg::PHASE_W-1:0] phase;
        logic [scvr_pkg::AMP_W-1:0]   amp;
        logic [scvr_pkg::VOLT_W-1:0]  volt;
    } reading_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b1;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [scvr_pkg::AXIS_W-1:0]   s_tdata  = '0;
    logic [0:0]                    s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [scvr_pkg::AXIS_W-1:0]   m_tdata;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [scvr_pkg::APB_AW-1:0]   paddr    = '0;
    logic [scvr_pkg::APB_DW-1:0]   pwdata   = '0;
    logic [scvr_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    // Predictor state
    scvr_pkg::cfg_t               cfg;
    logic [scvr_pkg::CNT_W-1:0]   cnt;
    int unsigned                  v_acc;
    int unsigned                  c_acc;
    int unsigned                  level;
    logic [scvr_pkg::VOLT_W-1:0]  volt_rd;
    logic [scvr_pkg::AMP_W-1:0]   amp_rd;
    logic [scvr_pkg::PHASE_W-1:0] phase;
    logic                         lim;
    logic                         gate;
    logic                         chan;
    reading_t                     readings_due[$];

    int errors = 0;
    int cycles = 0;
    bit calm   = 1'b0;
    int v_lvl  = 512;
    int w_lvl  = 25000;

    supply_current_voltage_regulator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= STALL_PCT);
    end

    function automatic void reset_model();
        cfg.current_setpoint = scvr_pkg::CFG_W'(scvr_pkg::CUR_SP_RST);
        cfg.voltage_setpoint = scvr_pkg::CFG_W'(scvr_pkg::VOLT_SP_RST);
        cfg.voltage_mode     = 1'b0;
        cfg.output_enable    = 1'b0;
        cnt     = '0;
        v_acc   = 0;
        c_acc   = 0;
        level   = 0;
        volt_rd = '0;
        amp_rd  = '0;
        phase   = scvr_pkg::PHASE_W'(scvr_pkg::PHASE_RST);
        lim     = 1'b0;
        gate    = 1'b0;
        chan    = CH_VOLT;
    endfunction

    // Shared counter: compare the incremented value, else store it wrapped to 4 bits.
    function automatic bit count_reaches(input int unsigned target);
        int unsigned nxt;
        nxt = cnt + 1;
        if (nxt == target)
        begin
            cnt = '0;
            return 1'b1;
        end
        cnt = scvr_pkg::CNT_W'(nxt);
        return 1'b0;
    endfunction

    function automatic void step_voltage(input logic [scvr_pkg::SAMPLE_W-1:0] smp);
        int unsigned avg;
        v_acc += smp;
        if (v_acc > scvr_pkg::ADC_MAX * N_VOLT)
            v_acc = scvr_pkg::ADC_MAX * N_VOLT;
        if (count_reaches(N_VOLT))
        begin
            avg     = v_acc / N_VOLT;
            volt_rd = scvr_pkg::VOLT_W'((avg * scvr_pkg::VOLT_SCALE) / scvr_pkg::ADC_MAX);
            v_acc   = 0;
            chan    = CH_CUR;
            lim     = (volt_rd >= cfg.voltage_setpoint) && cfg.voltage_mode;
        end
    endfunction

    function automatic void step_current(input logic [scvr_pkg::WSUM_W-1:0] ws);
        int unsigned clamped;
        c_acc += level;
        if (c_acc > scvr_pkg::CACC_CAP)
            c_acc = scvr_pkg::CACC_CAP;
        if (count_reaches(scvr_pkg::CUR_LEVELS))
        begin
            amp_rd = scvr_pkg::AMP_W'(c_acc / scvr_pkg::CUR_LEVELS / 17);
            c_acc  = 0;
            chan   = CH_VOLT;
            // Hold the phase while the voltage limit rules.
            if (!lim || !cfg.voltage_mode)
            begin
                if (cfg.current_setpoint > amp_rd && phase > scvr_pkg::PHASE_LOW)
                    phase--;
                if (cfg.current_setpoint < amp_rd && phase < scvr_pkg::PHASE_HIGH)
                    phase++;
            end
            if ((cfg.voltage_mode || lim) && cfg.output_enable)
                gate = (cfg.voltage_setpoint >= volt_rd);
        end
        clamped = (ws > WIN_FULL) ? WIN_FULL : ws;
        level   = (clamped * scvr_pkg::LEVEL_MAX) / WIN_FULL;
    endfunction

    function automatic void predict_event(input logic func,
                                          input logic [scvr_pkg::SAMPLE_W-1:0] smp,
                                          input logic [scvr_pkg::WSUM_W-1:0] ws);
        logic     run_cur;
        reading_t r;
        run_cur = func;
        if (func == CH_VOLT)
        begin
            step_voltage(smp);
            // The event that closes the voltage average runs the current step too.
            if (chan == CH_CUR)
                run_cur = 1'b1;
        end
        if (run_cur)
            step_current(ws);
        r.chan  = chan;
        r.gate  = gate;
        r.limit = lim;
        r.phase = phase;
        r.amp   = amp_rd;
        r.volt  = volt_rd;
        readings_due.push_back(r);
    endfunction

    task automatic send_event(input logic func, input logic [scvr_pkg::SAMPLE_W-1:0] smp,
                              input logic [scvr_pkg::WSUM_W-1:0] ws);
        while (!calm && $urandom_range(99) < STALL_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(scvr_pkg::AXIS_W - scvr_pkg::SAMPLE_W - scvr_pkg::WSUM_W){1'b0}},
                     ws, smp};
        do
            @(posedge clk);
        while (!s_tready);
        predict_event(func, smp, ws);
    endtask

    function automatic logic [scvr_pkg::SAMPLE_W-1:0] pick_sample();
        int v;
        if ($urandom_range(9) == 0)
            return scvr_pkg::SAMPLE_W'($urandom);
        v = v_lvl + int'($urandom_range(32)) - 16;
        if (v < 0)
            v = 0;
        if (v > scvr_pkg::ADC_MAX)
            v = scvr_pkg::ADC_MAX;
        return scvr_pkg::SAMPLE_W'(v);
    endfunction

    function automatic logic [scvr_pkg::WSUM_W-1:0] pick_wsum();
        int w;
        if ($urandom_range(9) == 0)
            return scvr_pkg::WSUM_W'($urandom);
        w = w_lvl + int'($urandom_range(4000)) - 2000;
        if (w < 0)
            w = 0;
        if (w > WIN_FULL)
            w = WIN_FULL;
        return scvr_pkg::WSUM_W'(w);
    endfunction

    // Convert the channel the regulator asks for next, as firmware would.
    task automatic send_tracked();
        if ($urandom_range(8) == 0)
        begin
            v_lvl = $urandom_range(scvr_pkg::ADC_MAX);
            w_lvl = ($urandom_range(7) == 0) ? 0 : $urandom_range(WIN_FULL);
        end
        send_event(chan, pick_sample(), pick_wsum());
    endtask

    task automatic run_mixed(input int n);
        repeat (n)
        begin
            if ($urandom_range(99) < 85)
                send_tracked();
            else
                send_event(1'($urandom_range(1)),
                           scvr_pkg::SAMPLE_W'($urandom_range(scvr_pkg::ADC_MAX)),
                           scvr_pkg::WSUM_W'($urandom_range(16'hFFFF)));
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input scvr_pkg::reg_idx_t idx,
                             input logic [scvr_pkg::APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            scvr_pkg::REG_CUR_SP:  cfg.current_setpoint = val[scvr_pkg::CFG_W-1:0];
            scvr_pkg::REG_VOLT_SP: cfg.voltage_setpoint = val[scvr_pkg::CFG_W-1:0];
            scvr_pkg::REG_VMODE:   cfg.voltage_mode     = val[0];
            scvr_pkg::REG_OEN:     cfg.output_enable    = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input int csp, input int vsp, input bit vmode, input bit oen);
        write_reg(scvr_pkg::REG_CUR_SP, csp);
        write_reg(scvr_pkg::REG_VOLT_SP, vsp);
        write_reg(scvr_pkg::REG_VMODE, scvr_pkg::APB_DW'(vmode));
        write_reg(scvr_pkg::REG_OEN, scvr_pkg::APB_DW'(oen));
    endtask

    // Field extremes under the reset settings, then steer the shared counter
    // past the voltage target so it wraps at 16 and both accumulators saturate.
    task automatic test_directed_extremes();
        logic [scvr_pkg::SAMPLE_W-1:0] samples [7] = '{10'd0, 10'd1023, 10'h2AA, 10'h155,
                                                       10'd1023, 10'd1023, 10'd1023};
        logic [scvr_pkg::WSUM_W-1:0]   sums [8]    = '{16'd0, 16'hFFFF, 16'hAAAA, 16'h5555,
                                                       16'd51150, 16'd51151, 16'hFFFF,
                                                       16'hFFFF};
        foreach (samples[i])
            send_event(CH_VOLT, samples[i], sums[i]);
        foreach (sums[i])
            send_event(CH_CUR, ~samples[i % 7], sums[i]);
        repeat (9) send_event(CH_VOLT, 10'd1023, 16'd0);
        send_event(CH_CUR, 10'd0, 16'd1000);
    endtask

    // Zero current target: every reading above it pushes the phase against 1000.
    task automatic test_phase_upper_bound();
        drain_results();
        configure(0, scvr_pkg::VOLT_SP_RST, 1'b0, 1'b1);
        repeat (90) send_tracked();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 5; p++)
        begin
            drain_results();
            case (p)
                0: configure(0, 0, 1'b1, 1'b1);
                1: configure(1023, 1023, 1'b1, 1'b1);
                2: configure($urandom_range(300), $urandom_range(160), 1'b1,
                             1'($urandom_range(1)));
                3: configure(1023, 0, 1'b0, 1'b1);
                default: configure($urandom_range(1023), $urandom_range(1023),
                                   1'($urandom_range(1)), 1'($urandom_range(1)));
            endcase
            calm = (p == 1);
            run_mixed(160);
        end
        calm = 1'b0;
    endtask

    // Maximum current target: current events only, so every second one steps
    // the phase down toward 10.
    task automatic test_phase_lower_bound();
        drain_results();
        configure(1023, $urandom_range(1023), 1'b0, 1'b1);
        repeat (1040) send_event(CH_CUR, pick_sample(), pick_wsum());
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        reading_t want;
        reading_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[29:0];
            if (readings_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with none expected, actual %h", $time, m_tdata);
            end
            else
            begin
                want = readings_due.pop_front();
                check_field("voltage_reading", want.volt, got.volt);
                check_field("current_reading", want.amp, got.amp);
                check_field("phase_delay", want.phase, got.phase);
                check_field("limit_flag", want.limit, got.limit);
                check_field("gate_on", want.gate, got.gate);
                check_field("next_channel", want.chan, got.chan);
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        reset_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_phase_upper_bound();
        test_random_settings();
        test_phase_lower_bound();
        drain_results();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
rtl/scvr_pkg.sv
rtl/scvr_cfg.sv
rtl/supply_current_voltage_regulator.sv
rtl/scvr_check.sv
tb/sv/supply_current_voltage_regulator_tb.sv
